// ===== src/deq_pkg.sv =====
// Package for the double-ended queue: sizes, codes, entry and cell control types.
package deq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_LIST       = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

  // Operation broadcast to every cell for the current cycle
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_ROTATE
  } op_t;

  typedef struct packed {
    logic [63:0] first;
    logic [7:0]  ninth;
  } name_t;

  typedef struct packed {
    op_t  op;
    logic head;    // cell holds the front entry
    logic tail;    // cell holds the back entry
    logic at_cnt;  // cell is the first free slot
  } cell_ctl_t;

  // Fit a count into the position field: zero-extend or keep the low bits
  function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] c);
    logic [CNT_W+POS_W-1:0] t;
    t = {{POS_W{1'b0}}, c};
    return t[POS_W-1:0];
  endfunction

endpackage

// ===== src/deq_cell.sv =====
// One storage cell of the queue row: holds an entry and takes it from a neighbour.
module deq_cell (
  input  logic              clk,
  input  deq_pkg::cell_ctl_t ctl,
  input  deq_pkg::name_t    load_d,
  input  deq_pkg::name_t    prev_d,
  input  deq_pkg::name_t    next_d,
  input  deq_pkg::name_t    wrap_d,
  output deq_pkg::name_t    q
);
  import deq_pkg::*;

  name_t data_r;
  name_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      OP_PUSH_FRONT: data_nxt = ctl.head ? load_d : prev_d;
      OP_PUSH_BACK:  data_nxt = ctl.at_cnt ? load_d : data_r;
      OP_POP_FRONT:  data_nxt = next_d;
      OP_ROTATE:     data_nxt = ctl.tail ? wrap_d : next_d;
      default:       data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// ===== src/double_ended_queue.sv =====
// Top level of the double-ended queue of short names, built on a row of cells.
//
// Input channel (in_valid/in_ready) takes one command item: push front, push
// back, pop front, pop back or list. Result channel (out_valid/out_ready)
// returns the result items from an output register.
// Entries live in a row of CAPACITY cells, front entry in cell 0. A push at the
// front shifts the whole row by one, a push at the back loads the first free
// cell, a pop at the front shifts the row back, a pop at the back only lowers
// the count.
// A push or pop item gives its single result in the cycle after it is
// accepted. A list item first enters listing, then gives one result per entry,
// as the row rotates the stored entries through cell 0 once, which leaves the
// order unchanged at the end. An empty list gives one result in the following
// cycle. Unused command codes are accepted and give no result.
// While a list runs, no new item is accepted. When the receiver stalls, the
// result is held in the output register and the row stops rotating.
// Reset clears the count, the listing state and the output valid; the cell
// contents are not reset and are only read where an entry was written.
module double_ended_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [63:0] in_name_chars_first,
  input  logic [7:0]  in_name_char_ninth,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_entry_chars_first,
  output logic [7:0]  out_entry_char_ninth,
  output logic [4:0]  out_position,
  output logic        out_last
);
  import deq_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  lst_r, lst_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  name_t             entry_r, entry_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              last_r, last_nxt;

  op_t    op;
  cmd_t   cmd;
  name_t  in_name;
  name_t  cell_q [CAPACITY];

  logic slot_free, in_fire, is_full, is_empty, list_step, list_end;

  assign cmd       = cmd_t'(in_command);
  assign in_name   = '{first: in_name_chars_first, ninth: in_name_char_ninth};
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign in_fire   = in_valid && in_ready;
  assign is_full   = (cnt_r == CNT_W'(CAPACITY));
  assign is_empty  = (cnt_r == '0);
  assign list_step = (state_r == S_LIST) && slot_free;
  assign list_end  = (lst_r == cnt_r - CNT_W'(1));

  // Row of cells; the ends see themselves as their missing neighbour
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t ctl;
    name_t     prev_d, next_d;

    assign ctl.op     = op;
    assign ctl.head   = (i == 0);
    assign ctl.tail   = (CNT_W'(i) == cnt_r - CNT_W'(1));
    assign ctl.at_cnt = (CNT_W'(i) == cnt_r);
    assign prev_d     = (i == 0) ? cell_q[i] : cell_q[(i == 0) ? 0 : i - 1];
    assign next_d     = (i == CAPACITY - 1) ? cell_q[i]
                                            : cell_q[(i == CAPACITY - 1) ? i : i + 1];

    deq_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .load_d (in_name),
      .prev_d (prev_d),
      .next_d (next_d),
      .wrap_d (cell_q[0]),
      .q      (cell_q[i])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && cmd == CMD_LIST && !is_empty) state_nxt = S_LIST;
      end
      S_LIST: begin
        if (list_step && list_end) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control and result formation
  always_comb begin
    op            = OP_HOLD;
    cnt_nxt       = cnt_r;
    lst_nxt       = lst_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    entry_nxt     = entry_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          entry_nxt = '0;
          last_nxt  = 1'b1;
          case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                status_nxt = STAT_FULL;
                pos_nxt    = to_pos(cnt_r);
              end else begin
                op         = (cmd == CMD_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                cnt_nxt    = cnt_r + CNT_W'(1);
                status_nxt = STAT_OK;
                pos_nxt    = to_pos(cnt_r + CNT_W'(1));
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              out_valid_nxt = 1'b1;
              if (is_empty) begin
                status_nxt = STAT_EMPTY;
                pos_nxt    = '0;
              end else begin
                // pop at the back only drops the count
                op         = (cmd == CMD_POP_FRONT) ? OP_POP_FRONT : OP_HOLD;
                cnt_nxt    = cnt_r - CNT_W'(1);
                status_nxt = STAT_OK;
                pos_nxt    = to_pos(cnt_r - CNT_W'(1));
              end
            end
            CMD_LIST: begin
              lst_nxt = '0;
              if (is_empty) begin
                out_valid_nxt = 1'b1;
                status_nxt    = STAT_EMPTY;
                pos_nxt       = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_LIST: begin
        if (list_step) begin
          // present the head entry and rotate the occupied part of the row
          out_valid_nxt = 1'b1;
          status_nxt    = STAT_OK;
          entry_nxt     = cell_q[0];
          pos_nxt       = to_pos(lst_r + CNT_W'(1));
          last_nxt      = list_end;
          op            = OP_ROTATE;
          lst_nxt       = lst_r + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      lst_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      lst_r       <= lst_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: hold while stalled
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    entry_r  <= entry_nxt;
    pos_r    <= pos_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_status            = status_r;
  assign out_entry_chars_first = entry_r.first;
  assign out_entry_char_ninth  = entry_r.ninth;
  assign out_position          = pos_r;
  assign out_last              = last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) |-> (cnt_r != '0) && (lst_r < cnt_r))
    else $error("listing beyond stored entries");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK) && !is_full)
      |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("push did not raise the count");

  a_list_hold_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) |=> $stable(cnt_r))
    else $error("count changed during listing");

endmodule

// ===== tb/double_ended_queue_test.sv =====
// Self-checking testbench for the double-ended queue of short names.
`timescale 1ns / 1ps

module double_ended_queue_test;
  import deq_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 335;
  localparam int CALM_TAIL    = 50;   // final items run with no idling on either side
  localparam int DRAIN_CYCLES = 40;   // comfortably longer than a full list
  localparam int STALL_LIMIT  = 400;  // cycles with no handshake before giving up

  // Command codes the block accepts and ignores
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  // One row of the directed table; typed rows carry their own single result
  typedef struct {
    logic [2:0] cmd;
    name_t      name;
    bit         typed;
    status_t    status;
    logic [4:0] pos;
  } stim_row_t;

  typedef struct {
    status_t    status;
    name_t      entry;
    logic [4:0] pos;
    logic       last;
  } deq_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_command = '0;
  logic [63:0] in_name_chars_first = '0;
  logic [7:0]  in_name_char_ninth = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [63:0] out_entry_chars_first;
  logic [7:0]  out_entry_char_ninth;
  logic [4:0]  out_position;
  logic        out_last;

  double_ended_queue dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_command            (in_command),
    .in_name_chars_first   (in_name_chars_first),
    .in_name_char_ninth    (in_name_char_ninth),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_entry_chars_first (out_entry_chars_first),
    .out_entry_char_ninth  (out_entry_char_ninth),
    .out_position          (out_position),
    .out_last              (out_last)
  );

  always #HALF_PERIOD clk = ~clk;

  // Shadow of the queue: a ring of names with its own front pointer and count
  name_t       ring [CAPACITY];
  int unsigned ring_front = 0;
  int unsigned ring_count = 0;

  // Results still owed by the block, oldest first
  deq_result_t awaited [$];

  // Idling switches, flipped per stretch of stimulus
  bit gaps_on   = 1'b0;
  bit stalls_on = 1'b0;

  int unsigned fails = 0;
  int unsigned items_done = 0;
  int unsigned lists_done = 0;
  int unsigned results_seen = 0;
  int unsigned full_seen = 0;
  int unsigned empty_seen = 0;

  function automatic deq_result_t mk_result(status_t st, name_t nm, int unsigned p,
                                            logic lst);
    deq_result_t r;
    r.status = st;
    r.entry  = nm;
    r.pos    = p[4:0];
    r.last   = lst;
    return r;
  endfunction

  // Advance the shadow queue by one command and queue up what it should return
  function automatic void deq_apply(logic [2:0] c, name_t nm);
    int unsigned slot;
    case (c)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (ring_count >= CAPACITY) begin
          // full: flag it, report the unchanged count, touch nothing
          awaited.push_back(mk_result(STAT_FULL, '0, ring_count, 1'b1));
        end else begin
          if (c == CMD_PUSH_FRONT) begin
            ring_front = (ring_front + CAPACITY - 1) % CAPACITY;
            slot = ring_front;
          end else begin
            slot = (ring_front + ring_count) % CAPACITY;
          end
          ring[slot] = nm;
          ring_count++;
          awaited.push_back(mk_result(STAT_OK, '0, ring_count, 1'b1));
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (ring_count == 0) begin
          awaited.push_back(mk_result(STAT_EMPTY, '0, 0, 1'b1));
        end else begin
          // pops hand back no name, only the new count
          if (c == CMD_POP_FRONT) ring_front = (ring_front + 1) % CAPACITY;
          ring_count--;
          awaited.push_back(mk_result(STAT_OK, '0, ring_count, 1'b1));
        end
      end
      CMD_LIST: begin
        if (ring_count == 0) begin
          awaited.push_back(mk_result(STAT_EMPTY, '0, 0, 1'b1));
        end else begin
          // front to back, one-based positions, last flag on the final entry
          for (int i = 0; i < ring_count; i++) begin
            awaited.push_back(mk_result(STAT_OK, ring[(ring_front + i) % CAPACITY], i + 1,
                                        (i + 1 == ring_count)));
          end
        end
      end
      default: ;  // unused codes: no state change, no result
    endcase
  endfunction

  function automatic stim_row_t stim_row(logic [2:0] c, name_t nm, bit typed, status_t st,
                                         logic [4:0] p);
    stim_row_t r;
    r.cmd    = c;
    r.name   = nm;
    r.typed  = typed;
    r.status = st;
    r.pos    = p;
    return r;
  endfunction

  // Pick a sender gap for the next item: mostly none, sometimes a burst
  function automatic int unsigned src_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) return $urandom_range(1, 10);
    return 0;
  endfunction

  // Present one item after an optional gap, hold it until taken, then predict
  task automatic drive_item(input logic [2:0] c, input name_t nm, input int unsigned gap);
    if (gap != 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid            <= 1'b1;
    in_command          <= c;
    in_name_chars_first <= nm.first;
    in_name_char_ninth  <= nm.ninth;
    do @(posedge clk); while (!in_ready);
    deq_apply(c, nm);
    if (c <= CMD_LIST) items_done++;
    if (c == CMD_LIST) lists_done++;
  endtask

  // Receiver: ready changes only at the falling edge, stalls come in bursts
  initial begin : sink
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 10) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result checker: compare each taken item with the oldest awaited result
  always @(posedge clk) begin
    deq_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited.size() == 0) begin
        $error("unexpected result: status %0d position %0d last %0d",
               out_status, out_position, out_last);
        fails++;
      end else begin
        want = awaited.pop_front();
        results_seen++;
        if (want.status == STAT_FULL) full_seen++;
        if (want.status == STAT_EMPTY) empty_seen++;
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fails++;
        end
        if (out_entry_chars_first !== want.entry.first) begin
          $error("entry_chars_first: expected %h, got %h",
                 want.entry.first, out_entry_chars_first);
          fails++;
        end
        if (out_entry_char_ninth !== want.entry.ninth) begin
          $error("entry_char_ninth: expected %h, got %h",
                 want.entry.ninth, out_entry_char_ninth);
          fails++;
        end
        if (out_position !== want.pos) begin
          $error("position: expected %0d, got %0d", want.pos, out_position);
          fails++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          fails++;
        end
      end
    end
  end

  // Watchdog: any cycle without a handshake on either side counts towards the limit
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no handshake for %0d cycles, %0d results outstanding",
             STALL_LIMIT, awaited.size());
    $display("[double_ended_queue] ERROR");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   tab [$];
    name_t       nm;
    logic [2:0]  c;
    int unsigned rand_start;
    int unsigned kind;
    int unsigned len;
    int unsigned pick;
    int unsigned push_pct;
    int unsigned pop_pct;
    bit          pressed;

    // Hold reset for the first cycles, release it on a falling edge
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed table: empty store first, then the lone-entry front pop,
    // an ignored code, a fill to capacity with extreme names, overflow and a full list
    tab.push_back(stim_row(CMD_POP_FRONT,  '0, 1'b1, STAT_EMPTY, 5'd0));
    tab.push_back(stim_row(CMD_POP_BACK,   '0, 1'b1, STAT_EMPTY, 5'd0));
    tab.push_back(stim_row(CMD_LIST,       '0, 1'b1, STAT_EMPTY, 5'd0));
    tab.push_back(stim_row(CMD_PUSH_FRONT, '1, 1'b1, STAT_OK,    5'd1));
    tab.push_back(stim_row(CMD_POP_FRONT,  '0, 1'b1, STAT_OK,    5'd0));
    tab.push_back(stim_row(CMD_UNUSED_HI,  '1, 1'b0, STAT_OK,    5'd0));
    for (int k = 0; k < CAPACITY; k++) begin
      if (k == 0) nm = '0;
      else if (k == 1) nm = '1;
      else nm = {"ENTRY_", 8'h41 + 8'(k), 8'h00, 8'h61 + 8'(k)};
      tab.push_back(stim_row(k[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, nm, 1'b0, STAT_OK,
                             5'd0));
    end
    tab.push_back(stim_row(CMD_PUSH_FRONT, {"OVERFLOW", 8'h21}, 1'b1, STAT_FULL,
                           5'(CAPACITY)));
    tab.push_back(stim_row(CMD_PUSH_BACK,  {"OVERFLOW", 8'h22}, 1'b1, STAT_FULL,
                           5'(CAPACITY)));
    tab.push_back(stim_row(CMD_LIST,       '0, 1'b0, STAT_OK,    5'd0));

    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    foreach (tab[i]) begin
      drive_item(tab[i].cmd, tab[i].name, src_gap());
      // typed rows replace the single predicted result with the one written down
      if (tab[i].typed)
        awaited[awaited.size() - 1] = mk_result(tab[i].status, '0, tab[i].pos, 1'b1);
    end

    // Random part in stretches that lean towards growing, shrinking or mixing,
    // so the store swings between empty and full many times
    rand_start = items_done;
    pressed = 1'b0;
    while (items_done - rand_start < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 2);
      len  = $urandom_range(4, 30);
      case (kind)
        0:       begin push_pct = 70; pop_pct = 15; end
        1:       begin push_pct = 15; pop_pct = 70; end
        default: begin push_pct = 40; pop_pct = 40; end
      endcase
      gaps_on   = $urandom_range(0, 2) != 0;
      stalls_on = $urandom_range(0, 2) != 0;
      repeat (len) begin
        if (items_done - rand_start >= RANDOM_ITEMS) break;
        // drop all idling for the closing stretch
        if (items_done - rand_start >= RANDOM_ITEMS - CALM_TAIL) begin
          gaps_on   = 1'b0;
          stalls_on = 1'b0;
        end
        pick = $urandom_range(0, 99);
        if (pick < push_pct)
          c = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        else if (pick < push_pct + pop_pct)
          c = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        else if (pick < 95)
          c = CMD_LIST;
        else
          c = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        // random names, with the all-zero and all-one names now and then
        nm.first = {$urandom, $urandom};
        nm.ninth = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
          0: nm = '0;
          1: nm = '1;
          default: ;
        endcase
        drive_item(c, nm, src_gap());
      end
      // Now and then, and after the first stretch for sure, let the block drain
      if (!pressed || $urandom_range(0, 3) == 0) begin
        pressed = 1'b1;
        @(negedge clk) in_valid <= 1'b0;
        while (awaited.size() != 0) @(posedge clk);
      end
    end

    // Drop valid, wait for every owed result, then watch a while for strays
    @(negedge clk) in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d commands (%0d lists) and checked %0d results,",
             items_done, lists_done, results_seen);
    $display("including %0d full and %0d empty responses", full_seen, empty_seen);
    if (fails == 0) begin
      $display("[double_ended_queue] OK");
    end else begin
      $display("[double_ended_queue] ERROR");
    end
    $finish;
  end

endmodule
